// ----- hdl/icfts_pkg.sv -----
package icfts_pkg;

    // Block size
    localparam int THREADS     = 4;
    localparam int CORES       = 4;

    // Fixed field layout: four 8-bit counts per packed word, one stall bit per thread
    localparam int LANE_FIELDS = 4;
    localparam int FIELD_W     = 8;
    localparam int PACK_W      = 32;
    localparam int STALL_W     = 4;
    localparam int CORE_W      = 2;
    localparam int OUT_W       = 2;

    // Derived widths
    localparam int TID_W       = $clog2(THREADS);
    localparam int CNT_W       = $clog2(THREADS + 1);
    localparam int SLOTS       = 2 * CORES;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int TOTAL_W     = FIELD_W + 2;

    // Configuration port
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = CFG_IDX_W'(1);

    // Front-end policy codes
    localparam logic POLICY_STRICT = 1'b0;
    localparam logic POLICY_ICOUNT = 1'b1;

    // What one lane reports to the merge
    typedef struct packed {
        logic               eligible;
        logic [TOTAL_W-1:0] total;
        logic [TID_W-1:0]   rank;
    } t_lane;

endpackage

// ----- hdl/icfts_ifs.sv -----
interface icfts_in_if import icfts_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [CORE_W-1:0] core_id;
    logic [PACK_W-1:0] fetch_queue_counts;
    logic [PACK_W-1:0] fetch_insn_queue_counts;
    logic [PACK_W-1:0] reorder_buffer_counts;
    logic [STALL_W-1:0] stall_mask;

    modport source (output valid, cmd, core_id, fetch_queue_counts,
                    fetch_insn_queue_counts, reorder_buffer_counts, stall_mask,
                    input ready);
    modport sink   (input valid, cmd, core_id, fetch_queue_counts,
                    fetch_insn_queue_counts, reorder_buffer_counts, stall_mask,
                    output ready);
endinterface

interface icfts_out_if import icfts_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] selected_thread;

    modport source (output valid, selected_thread, input ready);
    modport sink   (input valid, selected_thread, output ready);
endinterface

interface icfts_cfg_if import icfts_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/icfts_lane.sv -----
module icfts_lane import icfts_pkg::*; (
    input  logic [TID_W-1:0]   i_lane_id,
    input  logic [FIELD_W-1:0] i_fq_count,
    input  logic [FIELD_W-1:0] i_fiq_count,
    input  logic [FIELD_W-1:0] i_rob_count,
    input  logic               i_stalled,
    input  logic [TID_W-1:0]   i_start,
    input  logic [CNT_W-1:0]   i_active,
    output t_lane              o_lane
);

    logic [CNT_W-1:0] id_ext;
    logic [CNT_W-1:0] start_ext;
    logic [CNT_W-1:0] rank_full;

    assign id_ext    = CNT_W'(i_lane_id);
    assign start_ext = CNT_W'(i_start);

    // Distance from the rotation start, wrapping at the active count
    always_comb begin
        if (id_ext >= start_ext) begin
            rank_full = id_ext - start_ext;
        end else begin
            rank_full = id_ext + i_active - start_ext;
        end
    end

    // Sum the three occupancies and qualify the lane
    assign o_lane.total    = TOTAL_W'(i_fq_count) + TOTAL_W'(i_fiq_count)
                           + TOTAL_W'(i_rob_count);
    assign o_lane.rank     = rank_full[TID_W-1:0];
    assign o_lane.eligible = !i_stalled && (id_ext < i_active);

endmodule

// ----- hdl/icfts_merge.sv -----
module icfts_merge import icfts_pkg::*; (
    input  t_lane            i_lanes [THREADS],
    input  logic [TID_W-1:0] i_start,
    input  logic             i_policy,
    input  logic             i_core_bad,
    output logic [TID_W-1:0] o_sel
);

    // ICOUNT: smallest eligible total wins, lowest rotation rank breaks ties; else the start; a bad core gives zero
    always_comb begin
        logic                       found;
        logic [TOTAL_W+TID_W-1:0]   best;
        logic [TID_W-1:0]           pick;
        found = 1'b0;
        best  = '0;
        pick  = i_start;
        if (i_policy == POLICY_ICOUNT) begin
            for (int t = 0; t < THREADS; t++) begin
                if (i_lanes[t].eligible &&
                    (!found || {i_lanes[t].total, i_lanes[t].rank} < best)) begin
                    found = 1'b1;
                    best  = {i_lanes[t].total, i_lanes[t].rank};
                    pick  = TID_W'(t);
                end
            end
        end
        if (i_core_bad) begin
            pick = '0;
        end
        o_sel = pick;
    end

endmodule

// ----- hdl/icount_fetch_thread_select_top.sv -----
// ICOUNT front-end thread selector. One item is accepted every clock cycle unless the
// output stalls. The lane stage reads and advances the per-core, per-schedule rotation
// pointer and sums the three queue counts in one lane per thread; the output stage merges
// the lanes (ICOUNT: smallest unstalled active total, first in rotation order on ties;
// strict: the rotation start) into the output register. Pointers live in flip-flops and
// are read and written in the same cycle, so consecutive items for the same core and
// schedule see each other's advance. Ready follows the output side combinationally;
// configuration writes are always taken and should be made while no item is in flight.
module icount_fetch_thread_select_top import icfts_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    icfts_cfg_if.sink  i_cfg,
    icfts_in_if.sink   i_in,
    icfts_out_if.source o_out
);

    // Configuration
    logic                  r_policy;
    logic [CFG_DATA_W-1:0] r_active_threads;

    // Rotation pointers, one per schedule and core
    logic [TID_W-1:0] r_ptr [SLOTS];

    // Lane stage
    logic             r_a_valid;
    t_lane            r_lane [THREADS];
    logic [TID_W-1:0] r_a_start;
    logic             r_a_policy;
    logic             r_a_bad;

    // Output stage
    logic             r_o_valid;
    logic [TID_W-1:0] r_o_sel;

    logic             out_adv;
    logic             a_adv;
    logic             in_acc;
    logic [CNT_W-1:0] active_n;
    logic [SLOT_W-1:0] slot;
    logic             core_bad;
    logic [TID_W-1:0] ptr;
    logic [TID_W-1:0] start;
    logic [TID_W-1:0] n_ptr;
    t_lane            lanes [THREADS];
    logic [TID_W-1:0] merge_sel;

    assign i_cfg.ready = 1'b1;

    // Take configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy         <= POLICY_ICOUNT;
            r_active_threads <= CFG_DATA_W'(THREADS);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_POLICY: r_policy         <= i_cfg.data[0];
                CFG_ACTIVE: r_active_threads <= i_cfg.data;
                default:    ;
            endcase
        end
    end

    // Pipeline flow
    assign out_adv    = !r_o_valid || o_out.ready;
    assign a_adv      = !r_a_valid || out_adv;
    assign i_in.ready = a_adv;
    assign in_acc     = i_in.valid && a_adv;

    // Clamp the active thread count to one..THREADS
    always_comb begin
        if (r_active_threads == '0) begin
            active_n = CNT_W'(1);
        end else if (r_active_threads > CFG_DATA_W'(THREADS)) begin
            active_n = CNT_W'(THREADS);
        end else begin
            active_n = CNT_W'(r_active_threads);
        end
    end

    // Pointer lookup and advance
    assign core_bad = ({1'b0, i_in.core_id} >= (CORE_W + 1)'(CORES));
    assign slot     = i_in.cmd ? SLOT_W'(CORES) + SLOT_W'(i_in.core_id)
                               : SLOT_W'(i_in.core_id);
    assign ptr      = r_ptr[slot];
    assign start    = (CNT_W'(ptr) < active_n) ? ptr : '0;
    assign n_ptr    = (CNT_W'(ptr) + CNT_W'(1) < active_n) ? ptr + TID_W'(1) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) begin
                r_ptr[s] <= '0;
            end
        end else if (in_acc && !core_bad) begin
            r_ptr[slot] <= n_ptr;
        end
    end

    // One lane per thread; threads beyond the packed fields count zero, never stall
    for (genvar g = 0; g < THREADS; g++) begin : g_lane
        logic [FIELD_W-1:0] fq;
        logic [FIELD_W-1:0] fiq;
        logic [FIELD_W-1:0] rob;
        logic               stl;
        if (g < LANE_FIELDS) begin : g_field
            assign fq  = i_in.fetch_queue_counts[g*FIELD_W +: FIELD_W];
            assign fiq = i_in.fetch_insn_queue_counts[g*FIELD_W +: FIELD_W];
            assign rob = i_in.reorder_buffer_counts[g*FIELD_W +: FIELD_W];
            assign stl = i_in.stall_mask[g];
        end else begin : g_empty
            assign fq  = '0;
            assign fiq = '0;
            assign rob = '0;
            assign stl = 1'b0;
        end
        icfts_lane u_lane (
            .i_lane_id   (TID_W'(g)),
            .i_fq_count  (fq),
            .i_fiq_count (fiq),
            .i_rob_count (rob),
            .i_stalled   (stl),
            .i_start     (start),
            .i_active    (active_n),
            .o_lane      (lanes[g])
        );
    end

    // Lane stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_adv) begin
            r_a_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_lane     <= lanes;
            r_a_start  <= start;
            r_a_policy <= r_policy;
            r_a_bad    <= core_bad;
        end
    end

    icfts_merge u_merge (
        .i_lanes    (r_lane),
        .i_start    (r_a_start),
        .i_policy   (r_a_policy),
        .i_core_bad (r_a_bad),
        .o_sel      (merge_sel)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_adv) begin
            r_o_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_a_valid) begin
            r_o_sel <= merge_sel;
        end
    end

    assign o_out.valid           = r_o_valid;
    assign o_out.selected_thread = OUT_W'(r_o_sel);

`ifndef SYNTHESIS
    logic any_eligible;
    always_comb begin
        any_eligible = 1'b0;
        for (int t = 0; t < THREADS; t++) begin
            any_eligible = any_eligible | r_lane[t].eligible;
        end
    end

    a_icount_pick_eligible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && r_a_policy == POLICY_ICOUNT && !r_a_bad && any_eligible
        |-> r_lane[merge_sel].eligible)
        else $error("picked thread is stalled or inactive");

    a_strict_is_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && out_adv && r_a_policy == POLICY_STRICT && !r_a_bad
        |=> r_o_sel == $past(r_a_start))
        else $error("strict mode did not return the pointer thread");

    a_lane_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && !out_adv |=> r_a_valid && $stable(r_a_start) && $stable(r_a_bad))
        else $error("lane stage overwritten while output stalled");

    a_pointer_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !core_bad |=> CNT_W'(r_ptr[$past(slot)]) < $past(active_n))
        else $error("pointer left the active range after advance");
`endif

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import icfts_pkg::*;

    localparam int CYCLE_LIMIT     = 500000;
    localparam int DRAIN_CYCLES    = 6;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int FIXED_SETTINGS  = 12;
    localparam int NUM_SETTINGS    = 14;

    // One selection request as the block sees it
    typedef struct {
        logic               cmd;
        logic [CORE_W-1:0]  core;
        logic [PACK_W-1:0]  fq;
        logic [PACK_W-1:0]  fiq;
        logic [PACK_W-1:0]  rob;
        logic [STALL_W-1:0] stall;
    } sel_req_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    icfts_cfg_if cfg_if ();
    icfts_in_if  in_if ();
    icfts_out_if out_if ();

    icount_fetch_thread_select_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    sel_req_t          req_queue[$];
    logic [OUT_W-1:0]  grant_queue[$];

    // Shadow of the selector's configuration and rotation pointers
    logic              policy_q;
    int                active_q;
    logic [TID_W-1:0]  rot_ptr [SLOTS];

    int mismatches;
    int checked;
    int cycles;
    int send_gap;
    int stall_left;
    bit quiet;
    bit in_fired;
    bit drained;

    // Work out the granted thread and advance the pointer of that core and schedule
    function automatic logic [OUT_W-1:0] pick_thread(sel_req_t r);
        int n;
        int slot;
        int ptr;
        int td;
        int best;
        int total;
        int i;
        logic [OUT_W-1:0] sel;
        n = active_q;
        if (n < 1) n = 1;
        if (n > THREADS) n = THREADS;
        // pointers for cmd clear first, then pointers for cmd set
        slot = r.cmd ? CORES + int'(r.core) : int'(r.core);
        ptr = int'(rot_ptr[slot]);
        td = (ptr < n) ? ptr : 0;
        sel = OUT_W'(td);
        if (policy_q == POLICY_ICOUNT) begin
            best = 32'h7fff_ffff;
            for (i = 0; i < n; i++) begin
                total = int'(r.fq[td*FIELD_W +: FIELD_W]) + int'(r.fiq[td*FIELD_W +: FIELD_W])
                      + int'(r.rob[td*FIELD_W +: FIELD_W]);
                if (!r.stall[td] && total < best) begin
                    best = total;
                    sel = OUT_W'(td);
                end
                td = (td + 1 < n) ? td + 1 : 0;
            end
        end
        rot_ptr[slot] = TID_W'((ptr + 1 < n) ? ptr + 1 : 0);
        return sel;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        else if (r < 85) return $urandom_range(1, 2);
        else if (r < 97) return $urandom_range(3, 8);
        else return $urandom_range(20, 40);
    endfunction

    function automatic logic [PACK_W-1:0] lanes(int t0, int t1, int t2, int t3);
        return {8'(t3), 8'(t2), 8'(t1), 8'(t0)};
    endfunction

    // Small values make ties common, the extremes push totals past one byte
    function automatic logic [PACK_W-1:0] rand_lanes(int shape);
        logic [PACK_W-1:0] v;
        logic [7:0]        b;
        int                t;
        v = $urandom();
        b = 8'($urandom());
        for (t = 0; t < LANE_FIELDS; t++) begin
            case (shape)
                0:       v[t*FIELD_W +: FIELD_W] = 8'($urandom_range(0, 3));
                1:       v[t*FIELD_W +: FIELD_W] = 8'($urandom());
                2:       v[t*FIELD_W +: FIELD_W] = $urandom_range(0, 1) ? 8'hff : 8'h00;
                3:       v[t*FIELD_W +: FIELD_W] = b;
                default: v[t*FIELD_W +: FIELD_W] = 8'($urandom_range(0, 15));
            endcase
        end
        return v;
    endfunction

    function automatic sel_req_t rand_req();
        sel_req_t r;
        int       shape;
        int       k;
        shape = $urandom_range(0, 4);
        r.cmd = 1'($urandom());
        r.core = CORE_W'($urandom());
        r.fq = rand_lanes(shape);
        r.fiq = rand_lanes(shape);
        r.rob = rand_lanes(shape);
        k = $urandom_range(0, 7);
        case (k)
            0:       r.stall = '1;
            1:       r.stall = '0;
            2:       r.stall = ~(STALL_W'(1) << $urandom_range(0, STALL_W - 1));
            default: r.stall = STALL_W'($urandom());
        endcase
        return r;
    endfunction

    task automatic push_req(logic c, logic [CORE_W-1:0] core, logic [PACK_W-1:0] fq,
                            logic [PACK_W-1:0] fiq, logic [PACK_W-1:0] rob,
                            logic [STALL_W-1:0] stall);
        sel_req_t r;
        r.cmd = c;
        r.core = core;
        r.fq = fq;
        r.fiq = fiq;
        r.rob = rob;
        r.stall = stall;
        req_queue.push_back(r);
    endtask

    task automatic report(input string what, input logic [OUT_W-1:0] got,
                          input logic [OUT_W-1:0] want);
        mismatches++;
        $display("ERROR at %0t: %s: got thread %0d, want thread %0d", $realtime, what, got,
                 want);
    endtask

    // Write both registers back to back, then release the port
    task automatic write_config(input logic pol, input int act);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= CFG_POLICY;
        cfg_if.data  <= CFG_DATA_W'(pol);
        do @(posedge i_clk); while (!cfg_if.ready);
        policy_q = pol;
        @(negedge i_clk);
        cfg_if.index <= CFG_ACTIVE;
        cfg_if.data  <= CFG_DATA_W'(act);
        do @(posedge i_clk); while (!cfg_if.ready);
        active_q = act;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(negedge i_clk); while (!drained);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Take accepted items into the prediction, check results, watch the clock
    always @(posedge i_clk) begin
        sel_req_t         r;
        logic [OUT_W-1:0] want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end else if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                r.cmd = in_if.cmd;
                r.core = in_if.core_id;
                r.fq = in_if.fetch_queue_counts;
                r.fiq = in_if.fetch_insn_queue_counts;
                r.rob = in_if.reorder_buffer_counts;
                r.stall = in_if.stall_mask;
                grant_queue.push_back(pick_thread(r));
                in_fired = 1'b1;
            end
            if (out_if.valid && out_if.ready) begin
                if (grant_queue.size() == 0) begin
                    report("selection with no item outstanding", out_if.selected_thread, '0);
                end else begin
                    want = grant_queue.pop_front();
                    checked++;
                    if (out_if.selected_thread !== want)
                        report("selected_thread", out_if.selected_thread, want);
                end
            end
            drained = (req_queue.size() == 0) && !in_if.valid && (grant_queue.size() == 0);
        end
    end

    // Present the next item once the current one is taken; hold it otherwise
    always @(negedge i_clk) begin
        sel_req_t r;
        if (in_fired || !in_if.valid) begin
            if (send_gap > 0) begin
                in_if.valid <= 1'b0;
                send_gap--;
            end else if (req_queue.size() > 0) begin
                r = req_queue.pop_front();
                in_if.valid                   <= 1'b1;
                in_if.cmd                     <= r.cmd;
                in_if.core_id                 <= r.core;
                in_if.fetch_queue_counts      <= r.fq;
                in_if.fetch_insn_queue_counts <= r.fiq;
                in_if.reorder_buffer_counts   <= r.rob;
                in_if.stall_mask              <= r.stall;
                send_gap = quiet ? 0 : gap_len();
            end else begin
                in_if.valid <= 1'b0;
            end
        end
        in_fired = 1'b0;
        // stall the result side now and then
        if (stall_left > 0) begin
            out_if.ready <= 1'b0;
            stall_left--;
        end else begin
            out_if.ready <= 1'b1;
            stall_left = quiet ? 0 : gap_len();
        end
    end

    initial begin
        logic pol_list [FIXED_SETTINGS];
        int   act_list [FIXED_SETTINGS];
        int   p;
        int   k;
        logic pol;
        int   act;

        pol_list = '{POLICY_STRICT, POLICY_ICOUNT, POLICY_ICOUNT,
                     POLICY_ICOUNT, POLICY_STRICT, POLICY_ICOUNT,
                     POLICY_ICOUNT, POLICY_STRICT, POLICY_ICOUNT,
                     POLICY_ICOUNT, POLICY_STRICT, POLICY_ICOUNT};
        act_list = '{4, 2, 3, 1, 2, 4, 0, 7, 5, 2, 1, 6};
        in_if.valid = 1'b0;
        in_if.cmd = 1'b0;
        in_if.core_id = '0;
        in_if.fetch_queue_counts = '0;
        in_if.fetch_insn_queue_counts = '0;
        in_if.reorder_buffer_counts = '0;
        in_if.stall_mask = '0;
        out_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_POLICY;
        cfg_if.data = '0;
        policy_q = POLICY_ICOUNT;
        active_q = 4;
        foreach (rot_ptr[i]) rot_ptr[i] = '0;
        mismatches = 0;
        checked = 0;
        cycles = 0;
        send_gap = 0;
        stall_left = 0;
        quiet = 1'b0;
        in_fired = 1'b0;
        drained = 1'b0;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items under the reset settings: all ties, extremes, stalls
        push_req(1'b0, 2'd0, '0, '0, '0, '0);
        push_req(1'b1, 2'd3, '1, '1, '1, '0);
        push_req(1'b0, 2'd0, $urandom(), $urandom(), $urandom(), '1);
        push_req(1'b0, 2'd1, lanes(5, 4, 3, 2), '0, '0, '0);
        push_req(1'b0, 2'd1, lanes(5, 4, 3, 2), '0, '0, 4'h8);
        push_req(1'b1, 2'd0, lanes(1, 0, 0, 1), '0, '0, '0);
        push_req(1'b1, 2'd0, lanes(1, 0, 0, 1), '0, '0, '0);
        push_req(1'b1, 2'd0, lanes(1, 0, 0, 1), '0, '0, '0);
        push_req(1'b0, 2'd2, '1, '1, lanes(8'hff, 8'hff, 8'hfe, 8'hff), '0);
        push_req(1'b0, 2'd2, '1, '1, '1, 4'he);
        push_req(1'b0, 2'd3, lanes(8'hff, 0, 0, 0), lanes(0, 8'h80, 0, 0),
                 lanes(0, 8'h7f, 0, 1), '0);
        push_req(1'b1, 2'd1, '0, '0, '0, 4'h7);
        push_req(1'b1, 2'd2, '0, lanes(0, 3, 2, 1), '0, '0);
        for (k = 0; k < 8; k++)
            push_req(k[0], CORE_W'(k >> 1), $urandom(), $urandom(), $urandom(),
                     STALL_W'($urandom()));
        wait_idle();

        // Random items over a sweep of settings, pointers left high before lowering
        for (p = 0; p < NUM_SETTINGS; p++) begin
            if (p < FIXED_SETTINGS) begin
                pol = pol_list[p];
                act = act_list[p];
            end else begin
                pol = 1'($urandom_range(0, 1));
                act = $urandom_range(0, 7);
            end
            write_config(pol, act);
            quiet = (p % 3 == 1);
            repeat (ITEMS_PER_PHASE) req_queue.push_back(rand_req());
            wait_idle();
        end

        $display("Checked %0d thread selections over %0d settings of policy and thread count",
                 checked, NUM_SETTINGS + 1);
        $display("Both schedules on every core, counts from zero to full, stall masks varied");
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/icfts_pkg.sv
hdl/icfts_ifs.sv
hdl/icfts_lane.sv
hdl/icfts_merge.sv
hdl/icount_fetch_thread_select_top.sv
tb/tb_top.sv
